// File: hw/rtl/chtp_pkg.sv
// chtp_pkg: types and fixed constants of the chained hash table probe counter
// request and result structs, command codes and controller states
// no dependencies
package chtp_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DIV_W     = 5;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned COUNT_MAX = 15;
  localparam int unsigned DIVIDEND_W = 32;

  localparam logic [DIV_W-1:0] DIV_RESET = 5'd13;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_value;
    logic [IDX_W-1:0] bucket_index;
  } chtp_in_t;

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] probe_count;
  } chtp_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LRD,
    ST_LEN,
    ST_SCAN,
    ST_RESP
  } chtp_state_t;

endpackage

// File: hw/rtl/chtp_ram.sv
// chtp_ram: generic single-write, single-read ram with registered read data
// no dependencies
module chtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/chtp_mod.sv
// chtp_mod: iterative remainder unit, restoring division four bits per cycle
// 32-bit dividend, narrow divisor; uses chtp_pkg
module chtp_mod
  import chtp_pkg::*;
#(
  parameter int unsigned DW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DW-1:0]         divisor,
  output logic                  done,
  output logic [DW-1:0]         remainder
);

  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned NUM_STEPS     = DIVIDEND_W / BITS_PER_STEP;
  localparam int unsigned SW            = $clog2(NUM_STEPS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]         dvs_r, dvs_nxt;
  logic [DW-1:0]         rem_step;

  // four restoring steps on the running remainder
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    r = rem_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      t = {r, quo_r[DIVIDEND_W-1-k]};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
      end
      r = t[DW-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = rem_step;
      quo_nxt  = quo_r << BITS_PER_STEP;
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(NUM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("remainder done held longer than one cycle");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("remainder unit restarted while busy");

endmodule

// File: hw/rtl/chained_hash_table_probe_count_unit.sv
// chained hash table with division hash, probe counting per request; uses chtp_pkg, chtp_mod, chtp_ram
// each insert or search hashes its key in the remainder unit and a query reduces its bucket index there;
// the bucket length is then read, and a search reads the stored entries of the bucket from the entry ram
// one at a time until a match or the end of the chain; an unused command code skips straight to the result
// one request at a time; a new request is taken while the last result waits at the output
// after reset the bucket length ram is cleared, one bucket a cycle
module chained_hash_table_probe_count_unit
  import chtp_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS  = 16,
  parameter int unsigned BUCKET_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  chtp_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output chtp_out_t        out_data,
  input  logic             cfg_we,
  input  logic [DIV_W-1:0] cfg_wdata
);

  localparam int unsigned BW        = $clog2(NUM_BUCKETS);
  localparam int unsigned DW        = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned ENT_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned AW        = $clog2(ENT_DEPTH);
  localparam int unsigned LW        = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned CW        = LW + 1;

  chtp_state_t      state_r, state_nxt;
  logic [DIV_W-1:0] cfg_r, cfg_nxt;
  logic [BW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [BW-1:0]    bucket_r, bucket_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    scan_idx_r, scan_idx_nxt;
  chtp_out_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  chtp_out_t        out_data_r, out_data_nxt;

  logic                  accept;
  logic                  out_load;
  logic [DW-1:0]         hash_div;
  logic                  mod_start;
  logic [DIVIDEND_W-1:0] mod_dividend;
  logic [DW-1:0]         mod_divisor;
  logic                  mod_done;
  logic [DW-1:0]         mod_rem;

  logic          len_we;
  logic [BW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic [LW-1:0] len_q;

  logic             ent_we;
  logic [AW-1:0]    ent_waddr;
  logic [AW-1:0]    ent_raddr;
  logic [KEY_W-1:0] ent_rdata;

  logic [CW-1:0] cnt;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CW-1:0] c);
    if (32'(c) > COUNT_MAX) begin
      return CNT_W'(COUNT_MAX);
    end
    return CNT_W'(c);
  endfunction

  // divisor zero acts as one, above the bucket count as the bucket count
  always_comb begin
    if (cfg_r == '0) begin
      hash_div = DW'(1);
    end else if (32'(cfg_r) > NUM_BUCKETS) begin
      hash_div = DW'(NUM_BUCKETS);
    end else begin
      hash_div = DW'(cfg_r);
    end
  end

  assign accept       = in_valid && !in_stall;
  assign in_stall     = (state_r != ST_IDLE);
  assign mod_start    = accept && (in_data.cmd inside {CMD_INSERT, CMD_SEARCH, CMD_QUERY});
  assign mod_dividend = (in_data.cmd == CMD_QUERY) ? DIVIDEND_W'(in_data.bucket_index)
                                                   : {1'b0, in_data.key_value};
  assign mod_divisor  = (in_data.cmd == CMD_QUERY) ? DW'(NUM_BUCKETS) : hash_div;
  assign out_load     = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  assign ent_raddr = (state_r == ST_SCAN) ? base_r + AW'({1'b0, scan_idx_r} + 1'b1) : base_r;
  assign ent_waddr = base_r + AW'(len_q);

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    bucket_nxt    = bucket_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    scan_idx_nxt  = scan_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    len_we        = 1'b0;
    len_waddr     = bucket_r;
    len_wdata     = len_q + 1'b1;
    ent_we        = 1'b0;
    cnt           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end

    case (state_r)
      ST_CLEAR: begin
        len_we      = 1'b1;
        len_waddr   = clr_cnt_r;
        len_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.cmd;
          key_nxt = in_data.key_value;
          res_nxt = '{status: STATUS_DONE, probe_count: '0};
          // unused command code: no table state touched
          state_nxt = mod_start ? ST_DIV : ST_RESP;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          bucket_nxt = mod_rem[BW-1:0];
          state_nxt  = ST_LRD;
        end
      end
      ST_LRD: begin
        base_nxt  = AW'(32'(bucket_r) * BUCKET_DEPTH);
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        state_nxt = ST_RESP;
        case (cmd_r)
          CMD_INSERT: begin
            if (32'(len_q) >= BUCKET_DEPTH) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              ent_we = 1'b1;
              len_we = 1'b1;
            end
          end
          CMD_SEARCH: begin
            len_nxt      = len_q;
            scan_idx_nxt = '0;
            if (len_q == '0) begin
              res_nxt.probe_count = CNT_W'(1);
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            cnt                 = {1'b0, len_q} + 1'b1;
            res_nxt.probe_count = sat_count(cnt);
          end
        endcase
      end
      ST_SCAN: begin
        // entry at scan_idx_r arrives now, next entry is being read
        if (ent_rdata == key_r) begin
          cnt                 = {1'b0, scan_idx_r} + 1'b1;
          res_nxt.probe_count = sat_count(cnt);
          state_nxt           = ST_RESP;
        end else if (scan_idx_r + 1'b1 == len_r) begin
          cnt                 = {1'b0, len_r} + 1'b1;
          res_nxt.probe_count = sat_count(cnt);
          state_nxt           = ST_RESP;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_r       <= DIV_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    bucket_r   <= bucket_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    scan_idx_r <= scan_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  chtp_mod #(
    .DW(DW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  chtp_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_BUCKETS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (bucket_r),
    .rdata (len_q)
  );

  chtp_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (key_r),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("controller idle right after taking a request");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> (32'(len_q) < BUCKET_DEPTH))
    else $error("insert written into a full bucket");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r < len_r))
    else $error("search walked past bucket length");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending result");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (in_stall && len_we))
    else $error("request taken during length clear");

endmodule

// File: tb/sv/tb_chained_hash_table_probe_count_unit.sv
// self-checking testbench for chained_hash_table_probe_count_unit
// drives requests from a queue, predicts probe counts with a shadow table, checks each result
// depends on chtp_pkg and the unit under test
module tb_chained_hash_table_probe_count_unit;
  import chtp_pkg::*;

  localparam int unsigned NUM_BUCKETS  = 16;
  localparam int unsigned BUCKET_DEPTH = 8;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  chtp_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  chtp_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [DIV_W-1:0] cfg_wdata = '0;

  chained_hash_table_probe_count_unit #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the table contents and the divisor register
  logic [KEY_W-1:0] stored_keys [NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned      chain_len [NUM_BUCKETS] = '{default: 0};
  logic [DIV_W-1:0] divisor_shadow = DIV_RESET;

  chtp_in_t         pending_requests [$];
  chtp_out_t        predicted_probes [$];
  logic [KEY_W-1:0] inserted_keys [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_ticket = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned home_bucket(logic [KEY_W-1:0] key);
    int unsigned d;
    d = divisor_shadow;
    if (d == 0) d = 1;
    if (d > NUM_BUCKETS) d = NUM_BUCKETS;
    return key % d;
  endfunction

  function automatic chtp_out_t apply_to_table(chtp_in_t req);
    chtp_out_t   res;
    int unsigned b;
    int unsigned len;
    int unsigned probes;
    res = '0;
    case (req.cmd)
      CMD_INSERT: begin
        b = home_bucket(req.key_value);
        len = chain_len[b];
        if (len >= BUCKET_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          stored_keys[b][len] = req.key_value;
          chain_len[b] = len + 1;
        end
      end
      CMD_SEARCH: begin
        b = home_bucket(req.key_value);
        probes = 1;
        for (int i = 0; i < chain_len[b]; i++) begin
          if (stored_keys[b][i] == req.key_value) break;
          probes++;
        end
        res.probe_count = CNT_W'((probes > COUNT_MAX) ? COUNT_MAX : probes);
      end
      CMD_QUERY: begin
        probes = chain_len[req.bucket_index % NUM_BUCKETS] + 1;
        res.probe_count = CNT_W'((probes > COUNT_MAX) ? COUNT_MAX : probes);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_fault(input string msg);
    if (fault_count < REPORT_MAX) $display("mismatch: %s", msg);
    fault_count++;
  endtask

  // request driver
  always @(posedge clk) begin : drive
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predicted_probes.push_back(apply_to_table(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_requests.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_requests.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : observe
    chtp_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_probes.size() == 0) begin
          report_fault($sformatf("result with none pending: status %0d count %0d",
                                 out_data.status, out_data.probe_count));
        end else begin
          want = predicted_probes.pop_front();
          if (out_data.status !== want.status)
            report_fault($sformatf("status expected %0d got %0d",
                                   want.status, out_data.status));
          if (out_data.probe_count !== want.probe_count)
            report_fault($sformatf("probe_count expected %0d got %0d",
                                   want.probe_count, out_data.probe_count));
        end
      end
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("chained_hash_table_probe_count_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [IDX_W-1:0] idx);
    chtp_in_t req;
    req.cmd = cmd;
    req.key_value = key;
    req.bucket_index = idx;
    pending_requests.push_back(req);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned reuse_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < reuse_pct && inserted_keys.size() != 0)
      return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    if (r < reuse_pct + 20) return KEY_W'($urandom_range(63));
    return KEY_W'($urandom);
  endfunction

  // mostly inserts and searches, the searches mostly of keys already stored, some queries and unused codes
  task automatic add_random_request();
    int unsigned r;
    logic [KEY_W-1:0] key;
    r = $urandom_range(99);
    if (r < 35) begin
      key = pick_key(20);
      inserted_keys.push_back(key);
      add_request(CMD_INSERT, key, IDX_W'($urandom));
    end else if (r < 75) begin
      add_request(CMD_SEARCH, pick_key(60), IDX_W'($urandom));
    end else if (r < 95) begin
      add_request(CMD_QUERY, KEY_W'($urandom), IDX_W'($urandom));
    end else begin
      add_request(CMD_UNUSED, KEY_W'($urandom), IDX_W'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || predicted_probes.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input logic [DIV_W-1:0] div, input int unsigned idle_pct,
                           input int unsigned stall_rate, input int unsigned count,
                           input bit long_hold);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= div;
    @(posedge clk);
    cfg_we <= 1'b0;
    divisor_shadow = div;
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    if (long_hold) hold_ticket++;
    repeat (count) add_random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset divisor of 13
    add_request(CMD_QUERY, '0, 4'd0);
    add_request(CMD_QUERY, KEY_MAX, 4'd15);     // bucket above the divisor stays empty
    add_request(CMD_SEARCH, '0, '0);            // search of an empty bucket
    add_request(CMD_INSERT, '0, '0);
    add_request(CMD_INSERT, 31'd13, '0);
    add_request(CMD_INSERT, KEY_MAX, 4'd15);
    add_request(CMD_SEARCH, 31'd13, '0);
    add_request(CMD_SEARCH, KEY_MAX, '0);
    add_request(CMD_SEARCH, 31'd26, '0);        // miss in a populated bucket
    add_request(CMD_INSERT, '0, '0);            // duplicate key
    add_request(CMD_SEARCH, '0, '0);
    add_request(CMD_INSERT, 31'd26, '0);
    add_request(CMD_INSERT, 31'd39, '0);
    add_request(CMD_INSERT, 31'd52, '0);
    add_request(CMD_INSERT, 31'd65, '0);
    add_request(CMD_INSERT, 31'd78, '0);        // bucket 0 now full
    add_request(CMD_INSERT, 31'd91, '0);        // rejected
    add_request(CMD_SEARCH, 31'd91, '0);
    add_request(CMD_QUERY, '0, 4'd0);
    add_request(CMD_UNUSED, KEY_MAX, 4'd15);
    add_request(CMD_UNUSED, '0, '0);
    add_request(CMD_QUERY, '0, 4'd12);
    add_request(CMD_QUERY, '0, 4'd9);
    inserted_keys.push_back(31'd13);
    inserted_keys.push_back(KEY_MAX);

    run_phase(5'd0, 0, 0, 60, 1'b0);            // zero divisor acts as one
    run_phase(5'd5, 60, 0, 90, 1'b0);
    run_phase(5'd16, 0, 60, 100, 1'b0);
    run_phase(5'd31, 20, 20, 100, 1'b0);        // above the bucket count
    run_phase(5'd1, 0, 0, 50, 1'b1);            // long output hold fills the unit
    run_phase(DIV_W'($urandom_range(15, 2)), 60, 60, 100, 1'b0);
    run_phase(5'd16, 20, 20, 100, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && predicted_probes.size() == 0) begin
      $display("chained_hash_table_probe_count_unit regression: pass");
    end else begin
      $display("chained_hash_table_probe_count_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/chtp_pkg.sv
hw/rtl/chtp_ram.sv
hw/rtl/chtp_mod.sv
hw/rtl/chained_hash_table_probe_count_unit.sv
tb/sv/tb_chained_hash_table_probe_count_unit.sv
